### hw/rtl/lspp_pkg.sv
// ----------------------------------------------------------------------------
// lspp_pkg - shared types and constants for the laser scan polar projection
// Register indices, field widths, CORDIC gain and arctangent table.
// ----------------------------------------------------------------------------
package lspp_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_START     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_FLOOR     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_CEILING   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP_NS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_ENABLES = 3'd5;

    localparam int EN_INTENSITY = 0;
    localparam int EN_INDEX     = 1;
    localparam int EN_DISTANCE  = 2;
    localparam int EN_STAMP     = 3;

    localparam int INDEX_W = 13;
    localparam int KEPT_W  = 14;
    localparam int STAMP_W = 45;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 184;

    // CORDIC datapath: Q16.18 magnitude with headroom for the gain
    localparam int X_W = 36;
    localparam int Z_W = 33;
    localparam int ATAN_IDX_W = 5;
    localparam logic [29:0] GAIN_Q30 = 30'h26DD3B6A;

    typedef struct packed {
        logic [31:0]        angle;
        logic [INDEX_W-1:0] index;
        logic               kept;
        logic [KEPT_W-1:0]  kept_total;
    } lspp_sample_t;

    typedef struct packed {
        logic [31:0] time_step_ns;
        logic [3:0]  channel_enables;
    } lspp_cfg_t;

    // atan(2^-i) as a fraction of a full turn, 2^32 per turn
    function automatic logic [31:0] atan_turn(input logic [ATAN_IDX_W-1:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

### hw/rtl/lspp_cordic.sv
// ----------------------------------------------------------------------------
// lspp_cordic - iterative CORDIC rotator
// Rotates (range, 0) by a binary angle, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module lspp_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] range_q16,
    input  logic [31:0] angle,
    output logic        done,
    output logic [31:0] pos_x,
    output logic [31:0] pos_y
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_LOAD = 2'd1;
    localparam logic [1:0] PH_ROT  = 2'd2;
    localparam logic [1:0] PH_FIN  = 2'd3;
    localparam logic [lspp_pkg::ATAN_IDX_W-1:0] LAST_STEP =
        lspp_pkg::ATAN_IDX_W'(CORDIC_STEPS - 1);

    logic [1:0]  phase_reg, phase_next;
    logic        done_reg;
    logic [61:0] prod_reg;
    logic        flip_reg;
    logic signed [lspp_pkg::Z_W-1:0] z_reg;
    logic signed [lspp_pkg::X_W-1:0] x_reg, y_reg;
    logic [lspp_pkg::ATAN_IDX_W-1:0] iter_reg;
    logic [31:0] pos_x_reg, pos_y_reg;

    logic        flip;
    logic [31:0] ang_quarter, a_fold;
    logic [62:0] prod_round;
    logic signed [lspp_pkg::X_W-1:0] dx, dy, x_rot, y_rot, x_fin, y_fin;
    logic signed [lspp_pkg::Z_W-1:0] atan_z, z_rot;

    function automatic logic [31:0] round_sat(input logic signed [lspp_pkg::X_W-1:0] v);
        logic signed [lspp_pkg::X_W-1:0] t;
        logic [31:0] r;
        t = (v + 36'sd2) >>> 2;
        if (t > 36'sd2147483647)
            r = 32'h7FFF_FFFF;
        else if (t < -36'sd2147483648)
            r = 32'h8000_0000;
        else
            r = t[31:0];
        return r;
    endfunction

    // fold the angle into the right half plane
    assign ang_quarter = angle + 32'h4000_0000;
    assign flip        = ang_quarter[31];
    assign a_fold      = flip ? (angle ^ 32'h8000_0000) : angle;

    assign prod_round = {1'b0, prod_reg} + 63'(1 << 27);

    assign dx     = y_reg >>> iter_reg;
    assign dy     = x_reg >>> iter_reg;
    assign atan_z = signed'({1'b0, lspp_pkg::atan_turn(iter_reg)});

    always_comb
    begin
        if (!z_reg[lspp_pkg::Z_W-1])
        begin
            x_rot = x_reg - dx;
            y_rot = y_reg + dy;
            z_rot = z_reg - atan_z;
        end
        else
        begin
            x_rot = x_reg + dx;
            y_rot = y_reg - dy;
            z_rot = z_reg + atan_z;
        end
    end

    assign x_fin = flip_reg ? -x_reg : x_reg;
    assign y_fin = flip_reg ? -y_reg : y_reg;

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_IDLE: if (start) phase_next = PH_LOAD;
            PH_LOAD: phase_next = PH_ROT;
            PH_ROT:  if (iter_reg == LAST_STEP) phase_next = PH_FIN;
            PH_FIN:  phase_next = PH_IDLE;
            default: phase_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= (phase_reg == PH_FIN);
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    prod_reg <= range_q16 * lspp_pkg::GAIN_Q30;
                    flip_reg <= flip;
                    z_reg    <= signed'({a_fold[31], a_fold});
                end
            end
            PH_LOAD:
            begin
                x_reg    <= signed'({1'b0, prod_round[62:28]});
                y_reg    <= '0;
                iter_reg <= '0;
            end
            PH_ROT:
            begin
                x_reg    <= x_rot;
                y_reg    <= y_rot;
                z_reg    <= z_rot;
                iter_reg <= iter_reg + 1'b1;
            end
            PH_FIN:
            begin
                pos_x_reg <= round_sat(x_fin);
                pos_y_reg <= round_sat(y_fin);
            end
            default: ;
        endcase
    end

    assign done  = done_reg;
    assign pos_x = pos_x_reg;
    assign pos_y = pos_y_reg;

endmodule

### hw/rtl/lspp_track.sv
// ----------------------------------------------------------------------------
// lspp_track - configuration registers and sweep tracking
// Holds the register file, sample index, beam angle and kept count.
// ----------------------------------------------------------------------------
module lspp_track #(
    parameter int MAX_POINTS = 8192
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [lspp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lspp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            take,
    input  logic [31:0]                     range_q16,
    input  logic                            last_sample,
    output lspp_pkg::lspp_sample_t          sample,
    output lspp_pkg::lspp_cfg_t             cfg
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_POINTS - 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

    logic [31:0] angle_start_reg, angle_step_reg, range_floor_reg, range_ceiling_reg;
    logic [31:0] time_step_reg;
    logic [3:0]  enables_reg;
    logic [IDX_W-1:0] index_reg;
    logic [CNT_W-1:0] kept_cnt_reg, kept_cnt_next;
    logic [31:0] angle_reg;
    logic        kept;
    logic [31:0] index_wide, kept_wide;

    assign kept = (range_q16 >= range_floor_reg) && (range_q16 < range_ceiling_reg);
    assign kept_cnt_next = (kept && (kept_cnt_reg < CNT_MAX)) ?
                           kept_cnt_reg + CNT_W'(1) : kept_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_start_reg   <= '0;
            angle_step_reg    <= '0;
            range_floor_reg   <= '0;
            range_ceiling_reg <= '1;
            time_step_reg     <= '0;
            enables_reg       <= '0;
            index_reg         <= '0;
            kept_cnt_reg      <= '0;
            angle_reg         <= '0;
        end
        else if (take)
        begin
            if (last_sample)
            begin
                index_reg    <= '0;
                kept_cnt_reg <= '0;
                angle_reg    <= angle_start_reg;
            end
            else
            begin
                kept_cnt_reg <= kept_cnt_next;
                if (index_reg < IDX_MAX)
                begin
                    index_reg <= index_reg + 1'b1;
                    angle_reg <= angle_reg + angle_step_reg;
                end
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lspp_pkg::REG_ANGLE_START:
                begin
                    angle_start_reg <= cfg_data;
                    if (index_reg == '0)
                        angle_reg <= cfg_data;
                end
                lspp_pkg::REG_ANGLE_STEP:      angle_step_reg    <= cfg_data;
                lspp_pkg::REG_RANGE_FLOOR:     range_floor_reg   <= cfg_data;
                lspp_pkg::REG_RANGE_CEILING:   range_ceiling_reg <= cfg_data;
                lspp_pkg::REG_TIME_STEP_NS:    time_step_reg     <= cfg_data;
                lspp_pkg::REG_CHANNEL_ENABLES: enables_reg       <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign index_wide = 32'(index_reg);
    assign kept_wide  = 32'(kept_cnt_next);

    assign sample.angle      = angle_reg;
    assign sample.index      = index_wide[lspp_pkg::INDEX_W-1:0];
    assign sample.kept       = kept;
    assign sample.kept_total = kept_wide[lspp_pkg::KEPT_W-1:0];

    assign cfg.time_step_ns    = time_step_reg;
    assign cfg.channel_enables = enables_reg;

endmodule

### hw/rtl/laser_scan_polar_projection_top.sv
// ----------------------------------------------------------------------------
// laser_scan_polar_projection_top - lidar range sample to Cartesian point
// Projects each range sample onto x/y by CORDIC and tags it with sweep data.
// ----------------------------------------------------------------------------
//  channel   dir  tdata / tuser / tlast
//  s_*       in   tdata: range_q16, intensity_in; tlast: last_sample
//  m_*       out  tdata: pos_x .. kept_total; tuser: kept; tlast: sweep_end
//  cfg_*     in   write only: cfg_we, cfg_index, cfg_data
//
//  One sample at a time passes through the single CORDIC unit, one micro-rotation per
//  cycle; the next sample is not taken until the rotator has finished the last one.
//  s_tready is high only while no sample is in the rotator; a finished
//  result waits in the output register, so the next sample may enter.
//  A stalled master side holds the following result until m_tready.
//  Reset is asynchronous; no clearing pass.
// ----------------------------------------------------------------------------
module laser_scan_polar_projection_top #(
    parameter int MAX_POINTS   = 8192,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lspp_pkg::S_TDATA_W-1:0]  s_tdata,   // range_q16, intensity_in
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // pos_x, pos_y, sample_index, distance_out, intensity_out, stamp_ns, kept_total
    output logic [lspp_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                            m_tuser,   // kept
    output logic                            m_tlast,
    input  logic                            cfg_we,
    input  logic [lspp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lspp_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BUSY = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       m_tvalid_reg;

    logic [31:0] range_reg;
    logic [15:0] inten_reg;
    logic        last_reg;
    logic        kept_reg;
    logic [lspp_pkg::INDEX_W-1:0] index_reg;
    logic [lspp_pkg::KEPT_W-1:0]  kept_total_reg;
    logic [lspp_pkg::STAMP_W-1:0] stamp_reg;

    logic [lspp_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic m_tuser_reg, m_tlast_reg;

    logic accept, out_free, load_out;
    logic cordic_done;
    logic [31:0] pos_x, pos_y;
    logic [3:0]  en;

    lspp_pkg::lspp_sample_t sample;
    lspp_pkg::lspp_cfg_t    cfg;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign load_out = out_free &&
                      (((state_reg == ST_BUSY) && cordic_done) || (state_reg == ST_HOLD));
    assign en       = cfg.channel_enables;

    lspp_track #(
        .MAX_POINTS (MAX_POINTS)
    ) u_track (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .take        (accept),
        .range_q16   (s_tdata[31:0]),
        .last_sample (s_tlast),
        .sample      (sample),
        .cfg         (cfg)
    );

    lspp_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept),
        .range_q16 (s_tdata[31:0]),
        .angle     (sample.angle),
        .done      (cordic_done),
        .pos_x     (pos_x),
        .pos_y     (pos_y)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_BUSY;
            ST_BUSY:
            begin
                if (cordic_done)
                    state_next = out_free ? ST_IDLE : ST_HOLD;
            end
            ST_HOLD: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            range_reg      <= s_tdata[31:0];
            inten_reg      <= s_tdata[47:32];
            last_reg       <= s_tlast;
            kept_reg       <= sample.kept;
            index_reg      <= sample.index;
            kept_total_reg <= sample.kept_total;
        end
        if (state_reg == ST_BUSY)
            stamp_reg <= lspp_pkg::STAMP_W'(index_reg) * lspp_pkg::STAMP_W'(cfg.time_step_ns);
        if (load_out)
        begin
            m_tdata_reg[31:0]    <= pos_x;
            m_tdata_reg[63:32]   <= pos_y;
            m_tdata_reg[76:64]   <= en[lspp_pkg::EN_INDEX] ? index_reg : '0;
            m_tdata_reg[108:77]  <= en[lspp_pkg::EN_DISTANCE] ? range_reg : '0;
            m_tdata_reg[124:109] <= en[lspp_pkg::EN_INTENSITY] ? inten_reg : '0;
            m_tdata_reg[169:125] <= en[lspp_pkg::EN_STAMP] ? stamp_reg : '0;
            m_tdata_reg[183:170] <= kept_total_reg;
            m_tuser_reg          <= kept_reg;
            m_tlast_reg          <= last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_BUSY) && !s_tready)
        else $error("accepted sample did not start the rotator");

    a_done_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cordic_done |-> (state_reg == ST_BUSY))
        else $error("rotator finished with no sample in flight");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> m_tvalid && (state_reg == ST_IDLE))
        else $error("result load lost");

    a_hold_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HOLD) |-> m_tvalid_reg)
        else $error("result held with empty output register");
`endif

endmodule

### test/lspp_point_checker.sv
// ----------------------------------------------------------------------------
// lspp_point_checker - scoreboard for the laser scan polar projection
// Follows the config port and the sample stream, rebuilds every projected point
// (CORDIC, range gate, sweep counters, gated echoes) and compares each result
// transaction field by field, in order, against the oldest predicted point.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module lspp_point_checker #(
    parameter int MAX_POINTS   = 8192,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [lspp_pkg::S_TDATA_W-1:0]  s_tdata,   // range_q16, intensity_in
    input  logic                            s_tlast,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // pos_x, pos_y, sample_index, distance_out, intensity_out, stamp_ns, kept_total
    input  logic [lspp_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                            m_tuser,   // kept
    input  logic                            m_tlast,
    input  logic                            cfg_we,
    input  logic [lspp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lspp_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              errors,
    output int                              pending
);

    localparam int X_LO     = 0;
    localparam int Y_LO     = 32;
    localparam int IDX_LO   = 64;
    localparam int DIST_LO  = IDX_LO + lspp_pkg::INDEX_W;
    localparam int INT_LO   = DIST_LO + 32;
    localparam int STAMP_LO = INT_LO + 16;
    localparam int KEPT_LO  = STAMP_LO + lspp_pkg::STAMP_W;

    localparam logic [63:0] CORDIC_GAIN = 64'h26DD3B6A;
    localparam longint      SAT_HI      = 64'sh7FFFFFFF;
    localparam longint      SAT_LO      = -64'sh80000000;

    typedef struct {
        logic                         kept;
        logic [31:0]                  pos_x;
        logic [31:0]                  pos_y;
        logic [lspp_pkg::INDEX_W-1:0] sample_index;
        logic [31:0]                  distance;
        logic [15:0]                  intensity;
        logic [lspp_pkg::STAMP_W-1:0] stamp;
        logic [lspp_pkg::KEPT_W-1:0]  kept_total;
        logic                         sweep_end;
    } point_t;

    point_t expected_points[$];

    logic [31:0]                  angle_start;
    logic [31:0]                  angle_step;
    logic [31:0]                  range_floor;
    logic [31:0]                  range_ceiling;
    logic [31:0]                  time_step_ns;
    logic [3:0]                   enables;
    logic [lspp_pkg::INDEX_W-1:0] sample_idx;
    logic [31:0]                  beam_angle;
    logic [lspp_pkg::KEPT_W-1:0]  kept_count;

    // arctangent of 2^-i in binary angle units
    function automatic longint arctan_step(input int i);
        case (i)
            0:  return 64'h20000000;
            1:  return 64'h12E4051E;
            2:  return 64'h09FB385B;
            3:  return 64'h051111D4;
            4:  return 64'h028B0D43;
            5:  return 64'h0145D7E1;
            6:  return 64'h00A2F61E;
            7:  return 64'h00517C55;
            8:  return 64'h0028BE53;
            9:  return 64'h00145F2F;
            10: return 64'h000A2F98;
            11: return 64'h000517CC;
            12: return 64'h00028BE6;
            13: return 64'h000145F3;
            14: return 64'h0000A2FA;
            15: return 64'h0000517D;
            16: return 64'h000028BE;
            17: return 64'h0000145F;
            18: return 64'h00000A30;
            19: return 64'h00000518;
            20: return 64'h0000028C;
            21: return 64'h00000146;
            22: return 64'h000000A3;
            23: return 64'h00000051;
            24: return 64'h00000029;
            25: return 64'h00000014;
            26: return 64'h0000000A;
            27: return 64'h00000005;
            28: return 64'h00000003;
            29: return 64'h00000001;
            30: return 64'h00000001;
            default: return 64'h0;
        endcase
    endfunction

    // Q16.18 back to Q16.16, round half up, clamp to 32-bit signed
    function automatic logic [31:0] to_q16(input longint v);
        longint r;
        r = (v + 2) >>> 2;
        if (r > SAT_HI)
            r = SAT_HI;
        if (r < SAT_LO)
            r = SAT_LO;
        return r[31:0];
    endfunction

    function automatic void project_point(input logic [31:0] r, input logic [31:0] ang,
                                          output logic [31:0] px, output logic [31:0] py);
        logic [31:0] shifted;
        logic        flip;
        logic [31:0] a;
        logic [63:0] scaled;
        longint      x;
        longint      y;
        longint      z;
        longint      dx;
        longint      dy;
        shifted = ang + 32'h40000000;
        flip    = shifted[31];
        a       = flip ? ang - 32'h80000000 : ang;
        z       = longint'($signed(a));
        scaled  = ({32'd0, r} * CORDIC_GAIN + (64'd1 << 27)) >> 28;
        x       = longint'(scaled);
        y       = 0;
        for (int i = 0; i < CORDIC_STEPS && i < 32; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - arctan_step(i);
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + arctan_step(i);
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        px = to_q16(x);
        py = to_q16(y);
    endfunction

    function automatic void compare_field(input string name, input logic [63:0] want,
                                          input logic [63:0] got);
        if (want !== got)
        begin
            errors = errors + 1;
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : scoreboard
        point_t      p;
        point_t      want;
        logic [31:0] r;
        logic [63:0] product;
        if (!rst_n)
        begin
            angle_start   = '0;
            angle_step    = '0;
            range_floor   = '0;
            range_ceiling = '1;
            time_step_ns  = '0;
            enables       = '0;
            sample_idx    = '0;
            beam_angle    = '0;
            kept_count    = '0;
            errors        = 0;
            expected_points.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    lspp_pkg::REG_ANGLE_START:
                    begin
                        angle_start = cfg_data;
                        if (sample_idx == '0)
                            beam_angle = cfg_data;
                    end
                    lspp_pkg::REG_ANGLE_STEP:      angle_step    = cfg_data;
                    lspp_pkg::REG_RANGE_FLOOR:     range_floor   = cfg_data;
                    lspp_pkg::REG_RANGE_CEILING:   range_ceiling = cfg_data;
                    lspp_pkg::REG_TIME_STEP_NS:    time_step_ns  = cfg_data;
                    lspp_pkg::REG_CHANNEL_ENABLES: enables       = cfg_data[3:0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready)
            begin
                r      = s_tdata[31:0];
                p.kept = (r >= range_floor) && (r < range_ceiling);
                project_point(r, beam_angle, p.pos_x, p.pos_y);
                if (p.kept && kept_count < MAX_POINTS)
                    kept_count = kept_count + 1'b1;
                product        = {51'd0, sample_idx} * {32'd0, time_step_ns};
                p.sample_index = enables[lspp_pkg::EN_INDEX] ? sample_idx : '0;
                p.distance     = enables[lspp_pkg::EN_DISTANCE] ? r : '0;
                p.intensity    = enables[lspp_pkg::EN_INTENSITY] ? s_tdata[47:32] : '0;
                p.stamp        = enables[lspp_pkg::EN_STAMP] ?
                                 product[lspp_pkg::STAMP_W-1:0] : '0;
                p.kept_total   = kept_count;
                p.sweep_end    = s_tlast;
                expected_points.push_back(p);
                if (s_tlast)
                begin
                    sample_idx = '0;
                    kept_count = '0;
                    beam_angle = angle_start;
                end
                else if (sample_idx < MAX_POINTS - 1)
                begin
                    sample_idx = sample_idx + 1'b1;
                    beam_angle = beam_angle + angle_step;
                end
            end

            if (m_tvalid && m_tready)
            begin
                if (expected_points.size() == 0)
                begin
                    errors = errors + 1;
                    $error("result transaction with no point expected");
                end
                else
                begin
                    want = expected_points.pop_front();
                    compare_field("kept", want.kept, m_tuser);
                    compare_field("pos_x", want.pos_x, m_tdata[X_LO +: 32]);
                    compare_field("pos_y", want.pos_y, m_tdata[Y_LO +: 32]);
                    compare_field("sample_index", want.sample_index,
                                  m_tdata[IDX_LO +: lspp_pkg::INDEX_W]);
                    compare_field("distance_out", want.distance, m_tdata[DIST_LO +: 32]);
                    compare_field("intensity_out", want.intensity, m_tdata[INT_LO +: 16]);
                    compare_field("stamp_ns", want.stamp,
                                  m_tdata[STAMP_LO +: lspp_pkg::STAMP_W]);
                    compare_field("kept_total", want.kept_total,
                                  m_tdata[KEPT_LO +: lspp_pkg::KEPT_W]);
                    compare_field("sweep_end", want.sweep_end, m_tlast);
                end
            end
            pending <= expected_points.size();
        end
    end

endmodule

### test/tb_laser_scan_polar_projection_top.sv
// ----------------------------------------------------------------------------
// tb_laser_scan_polar_projection_top - stimulus and verdict for the projection
// Directed sweeps over angle quadrants, range gate edges, saturation, channel
// enables and mid-sweep register writes, one longer sweep with every point
// kept, then random-sample sweeps under edge and random configs, most with stalls on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_laser_scan_polar_projection_top;

    localparam int MAX_POINTS   = 8192;
    localparam int CORDIC_STEPS = 16;
    localparam int SETTLE       = CORDIC_STEPS + 12;
    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int LONG_SWEEP   = 64;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 36;

    localparam logic [lspp_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [lspp_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [lspp_pkg::S_TDATA_W-1:0]  s_tdata   = '0;
    logic                            s_tlast   = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [lspp_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                            m_tuser;
    logic                            m_tlast;
    logic                            cfg_we    = 1'b0;
    logic [lspp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [lspp_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    int   errors;
    int   pending;
    int   quiet_cycles = 0;
    int   hold_left    = 0;
    logic hold_req     = 1'b0;
    logic rx_calm      = 1'b0;
    logic tx_calm      = 1'b0;
    logic [31:0] cur_floor = '0;
    logic [31:0] cur_ceil  = '1;

    always #1 clk = ~clk;

    laser_scan_polar_projection_top #(
        .MAX_POINTS  (MAX_POINTS),
        .CORDIC_STEPS(CORDIC_STEPS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    lspp_point_checker #(
        .MAX_POINTS  (MAX_POINTS),
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .errors   (errors),
        .pending  (pending)
    );

    // result side: random back-pressure, or a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_left != 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req)
        begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
        end
        else
            m_tready <= rx_calm || ($urandom_range(0, 99) >= 36);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic write_reg(input logic [lspp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == lspp_pkg::REG_RANGE_FLOOR)
            cur_floor = value;
        if (idx == lspp_pkg::REG_RANGE_CEILING)
            cur_ceil = value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_sample(input logic [31:0] range_q16, input logic [15:0] intensity,
                               input logic last);
        int gap;
        if (!tx_calm && $urandom_range(0, 99) < 36)
        begin
            gap = $urandom_range(1, 48);
            repeat (gap)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {intensity, range_q16};
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // drain every outstanding point, then let the rotator settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_range();
        case ($urandom_range(0, 9))
            0:       return 32'h0;
            1:       return 32'hFFFFFFFF;
            2:       return cur_floor;
            3:       return cur_floor - 1;
            4:       return cur_ceil;
            5:       return cur_ceil - 1;
            6:       return $urandom_range(0, 32'h000FFFFF);
            default: return $urandom;
        endcase
    endfunction

    task automatic setup_phase(input int phase);
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] tmp;
        case (phase)
            0:
            begin
                write_reg(lspp_pkg::REG_ANGLE_START, 32'h80000000);
                write_reg(lspp_pkg::REG_ANGLE_STEP, 32'h7FFFFFFF);
                write_reg(lspp_pkg::REG_RANGE_FLOOR, 32'hFFFFFFFF);
                write_reg(lspp_pkg::REG_RANGE_CEILING, 32'hFFFFFFFF);
                write_reg(lspp_pkg::REG_TIME_STEP_NS, 32'hFFFFFFFF);
                write_reg(lspp_pkg::REG_CHANNEL_ENABLES, 32'hF);
            end
            1:
            begin
                write_reg(lspp_pkg::REG_ANGLE_START, 32'h0);
                write_reg(lspp_pkg::REG_ANGLE_STEP, 32'h80000000);
                write_reg(lspp_pkg::REG_RANGE_FLOOR, 32'h0);
                write_reg(lspp_pkg::REG_RANGE_CEILING, 32'h0);
                write_reg(lspp_pkg::REG_TIME_STEP_NS, 32'h0);
                write_reg(lspp_pkg::REG_CHANNEL_ENABLES, 32'h0);
            end
            default:
            begin
                lo = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h00FFFFFF);
                hi = $urandom;
                if ($urandom_range(0, 3) != 0 && lo > hi)
                begin
                    tmp = lo;
                    lo  = hi;
                    hi  = tmp;
                end
                write_reg(lspp_pkg::REG_ANGLE_STEP,
                          $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h00FFFFFF));
                write_reg(lspp_pkg::REG_RANGE_FLOOR, lo);
                write_reg(lspp_pkg::REG_RANGE_CEILING, hi);
                write_reg(lspp_pkg::REG_TIME_STEP_NS, $urandom);
                write_reg(lspp_pkg::REG_CHANNEL_ENABLES, $urandom_range(0, 15));
                write_reg(lspp_pkg::REG_ANGLE_START, $urandom);
            end
        endcase
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: echoes off, ceiling all ones
        send_sample(32'h0, 16'hFFFF, 1'b0);
        send_sample(32'hFFFFFFFF, 16'h0, 1'b1);
        wait_idle();

        write_reg(REG_SPARE_LO, 32'hFFFFFFFF);
        write_reg(REG_SPARE_HI, 32'h12345678);
        write_reg(lspp_pkg::REG_ANGLE_START, 32'h0);
        write_reg(lspp_pkg::REG_ANGLE_STEP, 32'h40000000);
        write_reg(lspp_pkg::REG_RANGE_FLOOR, 32'h00010000);
        write_reg(lspp_pkg::REG_RANGE_CEILING, 32'h00020000);
        write_reg(lspp_pkg::REG_TIME_STEP_NS, 32'hFFFFFFFF);
        write_reg(lspp_pkg::REG_CHANNEL_ENABLES, 32'hF);
        // quarter-turn steps visit every quadrant
        send_sample(32'h0000FFFF, 16'h0001, 1'b0);
        send_sample(32'h00010000, 16'h8000, 1'b0);
        send_sample(32'h0001FFFF, 16'hFFFF, 1'b0);
        send_sample(32'h00020000, 16'h0000, 1'b0);
        send_sample(32'hFFFFFFFF, 16'h5A5A, 1'b0);
        send_sample(32'h7FFFFFFF, 16'hA5A5, 1'b0);
        send_sample(32'h12345678, 16'h1234, 1'b0);
        send_sample(32'h00018000, 16'hFEDC, 1'b1);
        wait_idle();

        write_reg(lspp_pkg::REG_ANGLE_STEP, 32'h3FFFFFFF);
        write_reg(lspp_pkg::REG_ANGLE_START, 32'hBFFFFFFF);
        send_sample(32'h00015555, 16'h0F0F, 1'b0);
        send_sample(32'hFFFFFFFF, 16'hF0F0, 1'b0);
        wait_idle();

        // mid-sweep: start waits for the next sweep, step applies at once
        write_reg(lspp_pkg::REG_ANGLE_START, 32'h40000000);
        write_reg(lspp_pkg::REG_ANGLE_STEP, 32'h80000000);
        send_sample(32'h00010001, 16'h1111, 1'b0);
        send_sample(32'hFFFFFFFE, 16'h2222, 1'b1);
        send_sample(32'h0001C000, 16'h3333, 1'b1);
        wait_idle();

        // empty gate, partial enables, start reloaded while at sweep start
        write_reg(lspp_pkg::REG_ANGLE_START, 32'hC0000000);
        write_reg(lspp_pkg::REG_CHANNEL_ENABLES, 32'h5);
        write_reg(lspp_pkg::REG_RANGE_FLOOR, 32'h00008000);
        write_reg(lspp_pkg::REG_RANGE_CEILING, 32'h00008000);
        write_reg(lspp_pkg::REG_TIME_STEP_NS, 32'h1);
        send_sample(32'h00008000, 16'h4444, 1'b0);
        send_sample(32'h00007FFF, 16'h5555, 1'b0);
        send_sample(32'h00008001, 16'h6666, 1'b0);
        send_sample($urandom, 16'($urandom), 1'b1);
        wait_idle();

        write_reg(lspp_pkg::REG_CHANNEL_ENABLES, 32'hA);
        write_reg(lspp_pkg::REG_RANGE_FLOOR, 32'hFFFFFFFF);
        write_reg(lspp_pkg::REG_RANGE_CEILING, 32'h0);
        send_sample(32'hFFFFFFFF, 16'h7777, 1'b0);
        send_sample(32'h0, 16'h8888, 1'b1);
        wait_idle();

        // one longer sweep with every point kept
        write_reg(lspp_pkg::REG_ANGLE_START, $urandom);
        write_reg(lspp_pkg::REG_ANGLE_STEP, 32'h00080000);
        write_reg(lspp_pkg::REG_RANGE_FLOOR, 32'h0);
        write_reg(lspp_pkg::REG_RANGE_CEILING, 32'hFFFFFFFF);
        write_reg(lspp_pkg::REG_TIME_STEP_NS, $urandom);
        write_reg(lspp_pkg::REG_CHANNEL_ENABLES, 32'hF);
        for (int n = 0; n < LONG_SWEEP; n++)
            send_sample($urandom_range(0, 32'hFFFFFFFE), 16'($urandom), n == LONG_SWEEP - 1);
        wait_idle();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            setup_phase(phase);
            rx_calm <= (phase == 6);
            tx_calm  = (phase == 6);
            if (phase == 4)
            begin
                // hold the result side off while samples keep coming
                hold_req <= 1'b1;
                @(posedge clk);
                hold_req <= 1'b0;
                tx_calm   = 1'b1;
                for (int k = 0; k < 12; k++)
                    send_sample(pick_range(), 16'($urandom), $urandom_range(0, 7) == 0);
                tx_calm   = 1'b0;
            end
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_sample(pick_range(), 16'($urandom), $urandom_range(0, 15) == 0);
            wait_idle();
        end

        if (errors == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### laser_scan_polar_projection_top.f
hw/rtl/lspp_pkg.sv
hw/rtl/lspp_cordic.sv
hw/rtl/lspp_track.sv
hw/rtl/laser_scan_polar_projection_top.sv
test/lspp_point_checker.sv
test/tb_laser_scan_polar_projection_top.sv
